[hdl/prmh_pkg.sv]
// Package for the packet reorder min-heap.
// Holds the heap entry type and field widths; no dependencies.
package prmh_pkg;

    localparam int KEY_W = 16;
    localparam int CNT_W = 8;
    localparam int TAG_W = 16;
    localparam int BSZ_W = 7;
    localparam int TOT_W = 16;
    localparam int MAX_REL = 64;

    localparam logic [0:0] CFG_BATCH_SIZE = 1'b0;
    localparam logic [0:0] CFG_TOTAL_PKTS = 1'b1;

    typedef struct packed {
        logic [KEY_W-1:0] key;
        logic [CNT_W-1:0] cnt;
        logic [TAG_W-1:0] tag;
    } entry_t;

endpackage

[hdl/packet_reorder_min_heap.sv]
// Packet reorder buffer on a binary min-heap held in one memory.
// Depends on prmh_pkg. A sequencer does all sift work, one memory access per cycle.
// Insert: per level climbed, read the parent (S_UPRD), then compare and write (S_UPCMP).
// Release: check root key, fetch last entry, sift it down, then the output handshake.
// Throughput: one item at a time; in_stall is high until the item's releases are all taken.
// Reset: control and counters clear; heap memory is not cleared (count marks valid entries).
module packet_reorder_min_heap
    import prmh_pkg::*;
#(
    parameter int HEAP_DEPTH = 64
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_we,
    input  logic [0:0]          cfg_index,
    input  logic [TOT_W-1:0]    cfg_data,
    input  logic                in_valid,
    output logic                in_stall,
    input  logic [KEY_W-1:0]    seq_num,
    input  logic [CNT_W-1:0]    item_count,
    input  logic [TAG_W-1:0]    payload_tag,
    output logic                out_valid,
    input  logic                out_stall,
    output logic [KEY_W-1:0]    out_seq_num,
    output logic [CNT_W-1:0]    out_item_count,
    output logic [TAG_W-1:0]    out_payload_tag,
    output logic                last_of_run,
    output logic                overflow_seen
);

    localparam int AW = $clog2(HEAP_DEPTH);
    localparam int CW = $clog2(HEAP_DEPTH + 1);
    localparam logic [CW-1:0] DEPTH_C = CW'(HEAP_DEPTH);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_UPRD  = 4'd1;
    localparam logic [3:0] S_UPCMP = 4'd2;
    localparam logic [3:0] S_CHK   = 4'd3;
    localparam logic [3:0] S_ROOT  = 4'd4;
    localparam logic [3:0] S_OUT   = 4'd5;
    localparam logic [3:0] S_LAST  = 4'd6;
    localparam logic [3:0] S_DNL   = 4'd7;
    localparam logic [3:0] S_DNR   = 4'd8;
    localparam logic [3:0] S_DNCMP = 4'd9;
    localparam logic [3:0] S_DNCUR = 4'd10;

    entry_t mem [HEAP_DEPTH];
    entry_t rd_data;
    logic [AW-1:0] rd_addr;
    logic          wr_en;
    logic [AW-1:0] wr_addr;
    entry_t        wr_data;

    logic [3:0]       state_reg, state_next;
    logic [CW-1:0]    count_reg, count_next;
    logic [KEY_W-1:0] expect_reg, expect_next;
    logic [BSZ_W-1:0] fill_reg, fill_next;
    logic [TOT_W-1:0] rcvd_reg, rcvd_next;
    logic             ovf_reg, ovf_next;
    logic [BSZ_W-1:0] bsize_reg;
    logic [TOT_W-1:0] total_reg;
    logic [AW-1:0]    pos_reg, pos_next;
    logic [AW-1:0]    best_reg, best_next;
    entry_t           cur_reg, cur_next;
    entry_t           cand_reg, cand_next;
    entry_t           outp_reg, outp_next;
    logic             has_cand_reg, has_cand_next;
    logic [6:0]       nrel_reg, nrel_next;
    logic             last_reg, last_next;

    logic [AW:0]      lidx, ridx;
    logic [AW-1:0]    parent;
    logic [BSZ_W-1:0] fill_inc;
    logic             attempt;
    logic [KEY_W-1:0] root_key;
    logic             out_last;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            count_reg  <= '0;
            expect_reg <= '0;
            fill_reg   <= '0;
            rcvd_reg   <= '0;
            ovf_reg    <= 1'b0;
            bsize_reg  <= BSZ_W'(8);
            total_reg  <= '1;
            nrel_reg   <= '0;
            last_reg   <= 1'b0;
            has_cand_reg <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            count_reg  <= count_next;
            expect_reg <= expect_next;
            fill_reg   <= fill_next;
            rcvd_reg   <= rcvd_next;
            ovf_reg    <= ovf_next;
            nrel_reg   <= nrel_next;
            last_reg   <= last_next;
            has_cand_reg <= has_cand_next;
            if (cfg_we)
            begin
                unique case (cfg_index)
                    CFG_BATCH_SIZE: bsize_reg <= cfg_data[BSZ_W-1:0];
                    CFG_TOTAL_PKTS: total_reg <= cfg_data;
                    default: ;
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pos_reg  <= pos_next;
        best_reg <= best_next;
        cur_reg  <= cur_next;
        cand_reg <= cand_next;
        outp_reg <= outp_next;
    end

    assign parent   = AW'((pos_reg - AW'(1)) >> 1);
    assign lidx     = {pos_reg, 1'b1};
    assign ridx     = {pos_reg, 1'b0} + (AW+1)'(2);
    assign fill_inc = fill_reg + BSZ_W'(1);
    assign attempt  = (fill_inc >= bsize_reg)
                   || ((rcvd_reg != '1) && ((rcvd_reg + TOT_W'(1)) == total_reg));

    always_comb
    begin
        state_next    = state_reg;
        count_next    = count_reg;
        expect_next   = expect_reg;
        fill_next     = fill_reg;
        rcvd_next     = rcvd_reg;
        ovf_next      = ovf_reg;
        pos_next      = pos_reg;
        best_next     = best_reg;
        cur_next      = cur_reg;
        cand_next     = cand_reg;
        outp_next     = outp_reg;
        has_cand_next = has_cand_reg;
        nrel_next     = nrel_reg;
        last_next     = last_reg;
        rd_addr       = '0;
        wr_en         = 1'b0;
        wr_addr       = '0;
        wr_data       = cur_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cur_next  = '{key: seq_num, cnt: item_count, tag: payload_tag};
                    fill_next = fill_inc;
                    if (rcvd_reg != '1)
                    begin
                        rcvd_next = rcvd_reg + TOT_W'(1);
                    end
                    nrel_next = '0;
                    if (attempt)
                    begin
                        fill_next = '0;
                    end
                    last_next = attempt;
                    if (count_reg == DEPTH_C)
                    begin
                        ovf_next   = 1'b1;
                        state_next = attempt ? S_CHK : S_IDLE;
                    end
                    else
                    begin
                        pos_next   = count_reg[AW-1:0];
                        count_next = count_reg + CW'(1);
                        state_next = S_UPRD;
                    end
                end
            end
            S_UPRD:
            begin
                if (pos_reg == '0)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = pos_reg;
                    state_next = last_reg ? S_CHK : S_IDLE;
                end
                else
                begin
                    rd_addr    = parent;
                    state_next = S_UPCMP;
                end
            end
            S_UPCMP:
            begin
                if (cur_reg.key < rd_data.key)
                begin
                    wr_en      = 1'b1;
                    wr_addr    = pos_reg;
                    wr_data    = rd_data;
                    pos_next   = parent;
                    state_next = S_UPRD;
                end
                else
                begin
                    wr_en      = 1'b1;
                    wr_addr    = pos_reg;
                    state_next = last_reg ? S_CHK : S_IDLE;
                end
            end
            S_CHK:
            begin
                rd_addr = '0;
                if (count_reg == '0 || nrel_reg == 7'(MAX_REL))
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    state_next = S_ROOT;
                end
            end
            S_ROOT:
            begin
                if (rd_data.key == expect_reg)
                begin
                    outp_next  = rd_data;
                    rd_addr    = AW'(count_reg - CW'(1));
                    state_next = S_LAST;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_LAST:
            begin
                cur_next    = rd_data;
                count_next  = count_reg - CW'(1);
                expect_next = expect_reg + KEY_W'(1);
                nrel_next   = nrel_reg + 7'd1;
                pos_next    = '0;
                state_next  = S_DNL;
            end
            S_DNL:
            begin
                best_next     = pos_reg;
                has_cand_next = 1'b0;
                if (lidx < (AW+1)'(count_reg))
                begin
                    rd_addr    = lidx[AW-1:0];
                    state_next = S_DNR;
                end
                else
                begin
                    wr_en      = (count_reg != '0);
                    wr_addr    = pos_reg;
                    state_next = S_OUT;
                end
            end
            S_DNR:
            begin
                if (rd_data.key < cur_reg.key)
                begin
                    cand_next     = rd_data;
                    best_next     = lidx[AW-1:0];
                    has_cand_next = 1'b1;
                end
                if (ridx < (AW+1)'(count_reg))
                begin
                    rd_addr    = ridx[AW-1:0];
                    state_next = S_DNCMP;
                end
                else
                begin
                    state_next = S_DNCUR;
                end
            end
            S_DNCMP:
            begin
                if (has_cand_reg ? (rd_data.key < cand_reg.key)
                                 : (rd_data.key < cur_reg.key))
                begin
                    cand_next     = rd_data;
                    best_next     = ridx[AW-1:0];
                    has_cand_next = 1'b1;
                end
                state_next = S_DNCUR;
            end
            S_DNCUR:
            begin
                wr_en   = 1'b1;
                wr_addr = pos_reg;
                if (has_cand_reg)
                begin
                    wr_data    = cand_reg;
                    pos_next   = best_reg;
                    state_next = S_DNL;
                end
                else
                begin
                    state_next = S_OUT;
                end
            end
            S_OUT:
            begin
                rd_addr = '0;
                if (!out_stall)
                begin
                    state_next = S_CHK;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // a sift that settled at the root leaves the new root in cur_reg
    assign root_key = (pos_reg == '0) ? cur_reg.key : rd_data.key;
    assign out_last = (count_reg == '0) || (nrel_reg == 7'(MAX_REL))
                   || (root_key != expect_reg);

    assign in_stall        = (state_reg != S_IDLE);
    assign out_valid       = (state_reg == S_OUT);
    assign out_seq_num     = outp_reg.key;
    assign out_item_count  = outp_reg.cnt;
    assign out_payload_tag = outp_reg.tag;
    assign last_of_run     = out_last;
    assign overflow_seen   = ovf_reg;

    assert property (@(posedge clk) disable iff (!rst_n) count_reg <= DEPTH_C)
        else $error("heap count above depth");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(out_seq_num))
        else $error("release dropped while stalled");
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_stall |=> expect_reg == $past(out_seq_num) + KEY_W'(1))
        else $error("expected number not advanced");
    assert property (@(posedge clk) disable iff (!rst_n) out_valid |-> in_stall)
        else $error("input open during release");

endmodule
